>>> rtl/cpia_pkg.sv
// cantor unpairing block: shared types and constants
// no dependencies
`timescale 1ns / 1ps
package cpia_pkg;
	localparam int OPERAND_W = 17;
	localparam int OUTCOME_W = 33;
	localparam int ADVANCE_W = 2;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef logic signed [OPERAND_W-1:0] operand_t;
	typedef logic signed [OUTCOME_W-1:0] outcome_t;
	typedef logic [ADVANCE_W-1:0] advance_t;
endpackage

>>> rtl/cpia_if.sv
// valid/ready stream interfaces for index and result channels
// depends on cpia_pkg
`timescale 1ns / 1ps
interface cpia_index_if #(parameter int INDEX_WIDTH = 32) ();
	logic valid;
	logic ready;
	logic [INDEX_WIDTH-1:0] index;
	modport source (output valid, output index, input ready);
	modport sink (input valid, input index, output ready);
endinterface

interface cpia_result_if ();
	logic valid;
	logic ready;
	cpia_pkg::operand_t first_operand;
	cpia_pkg::operand_t second_operand;
	cpia_pkg::outcome_t outcome;
	cpia_pkg::advance_t index_advance;
	modport source (output valid, output first_operand, output second_operand,
		output outcome, output index_advance, input ready);
	modport sink (input valid, input first_operand, input second_operand,
		input outcome, input index_advance, output ready);
endinterface

>>> rtl/cantor_pair_integer_arith.sv
// cantor unpairing with zigzag operands and one configured arithmetic operation
// pipeline at 32 bits: 19 root stages, 2 unpair, 1 lane select, 17 divider, 1 out
// throughput: one index per cycle when not stalled; three unpair lanes (n, n+1, n+2) run in parallel
// stall: all stages hold while the output register is full and not taken
// reset: operation clears to add, all valid bits clear
`timescale 1ns / 1ps
module cantor_pair_integer_arith #(
	parameter int INDEX_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [1:0] cfg_wdata,
	cpia_index_if.sink in_ch,
	cpia_result_if.source out_ch
);
	import cpia_pkg::*;
	localparam int NW = INDEX_WIDTH + 1;
	localparam int OW = (INDEX_WIDTH + 1) / 2 + 1;
	localparam int PW = 2 * OW + ADVANCE_W + OUTCOME_W + 2;

	typedef logic signed [OW-1:0] opw_t;

	op_t op_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_ADD;
		end else if (cfg_we) begin
			op_q <= op_t'(cfg_wdata);
		end
	end

	logic en;
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	logic [NW-1:0] n0;
	assign n0 = NW'(in_ch.index);
	logic acc;
	assign acc = in_ch.valid;

	logic v0, v1, v2;
	opw_t a0, b0, a1, b1, a2, b2;
	logic [1:0] op0, op1, op2;
	cpia_unpair #(.NW(NW), .TW(2), .OW(OW)) u_l0 (.clk, .arst_n, .en, .vin(acc), .n(n0),
		.tag_in(op_q), .vout(v0), .tag_out(op0), .a(a0), .b(b0));
	cpia_unpair #(.NW(NW), .TW(2), .OW(OW)) u_l1 (.clk, .arst_n, .en, .vin(acc),
		.n(n0 + NW'(1)), .tag_in(op_q), .vout(v1), .tag_out(op1), .a(a1), .b(b1));
	cpia_unpair #(.NW(NW), .TW(2), .OW(OW)) u_l2 (.clk, .arst_n, .en, .vin(acc),
		.n(n0 + NW'(2)), .tag_in(op_q), .vout(v2), .tag_out(op2), .a(a2), .b(b2));

	// choose lane and form non-divide result
	op_t op_c;
	opw_t a_c, b_c;
	advance_t adv_c;
	outcome_t r_c;
	logic signed [2*OW-1:0] prod_c;
	assign op_c = op_t'(op0 & op1 & op2);
	always_comb begin
		a_c = a0;
		b_c = b0;
		adv_c = '0;
		if (op_c == OP_DIV && b0 == '0) begin
			if (b1 != '0) begin
				a_c = a1;
				b_c = b1;
				adv_c = advance_t'(1);
			end else begin
				a_c = a2;
				b_c = b2;
				adv_c = advance_t'(2);
			end
		end
	end

	opw_t a_s1, b_s1;
	advance_t adv_s1;
	op_t op_s1;
	logic v_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= v0 & v1 & v2;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= a_c;
			b_s1 <= b_c;
			adv_s1 <= adv_c;
			op_s1 <= op_c;
		end
	end

	assign prod_c = a_s1 * b_s1;
	always_comb begin
		case (op_s1)
			OP_ADD: r_c = outcome_t'(a_s1) + outcome_t'(b_s1);
			OP_SUB: r_c = outcome_t'(a_s1) - outcome_t'(b_s1);
			OP_MUL: r_c = outcome_t'(prod_c);
			default: r_c = '0;
		endcase
	end

	logic [PW-1:0] pay_in, pay_out;
	assign pay_in = {a_s1, b_s1, adv_s1, r_c, op_s1};
	logic v_d;
	outcome_t q_d;
	cpia_divide #(.PW(PW), .OW(OW)) u_div (.clk, .arst_n, .en, .vin(v_s1), .a(a_s1),
		.b(b_s1), .pay_in, .vout(v_d), .pay_out, .q(q_d));

	opw_t a_o, b_o;
	advance_t adv_o;
	outcome_t r_o;
	logic [1:0] op_o;
	assign {a_o, b_o, adv_o, r_o, op_o} = pay_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.valid <= 1'b0;
		end else if (en) begin
			out_ch.valid <= v_d;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.first_operand <= operand_t'(a_o);
			out_ch.second_operand <= operand_t'(b_o);
			out_ch.index_advance <= adv_o;
			out_ch.outcome <= (op_o == OP_DIV) ? q_d : r_o;
		end
	end
endmodule

>>> rtl/cpia_unpair.sv
// pipelined cantor unpairing: square root one bit per stage, then split and zigzag
// no dependencies; root stages, then triangle and output registers, all stall with en
`timescale 1ns / 1ps
module cpia_unpair #(
	parameter int NW = 33,
	parameter int TW = 2,
	parameter int OW = 17
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vin,
	input  logic [NW-1:0] n,
	input  logic [TW-1:0] tag_in,
	output logic vout,
	output logic [TW-1:0] tag_out,
	output logic signed [OW-1:0] a,
	output logic signed [OW-1:0] b
);
	localparam int VW = NW + 4;
	localparam int RW = (VW + 1) / 2;

	logic [RW:0] v_s;
	logic [NW-1:0] n_s [RW+1];
	logic [VW-1:0] rem_s [RW+1];
	logic [RW-1:0] root_s [RW+1];
	logic [TW-1:0] tag_s [RW+1];

	assign v_s[0] = vin;
	assign n_s[0] = n;
	assign rem_s[0] = {n, 3'b000} + VW'(1);
	assign root_s[0] = '0;
	assign tag_s[0] = tag_in;

	for (genvar i = 0; i < RW; i++) begin : g_sq
		localparam int K = RW - 1 - i;
		logic [VW-1:0] trial;
		logic [VW-1:0] rwide;
		assign rwide = VW'(root_s[i]);
		assign trial = (rwide << (K + 1)) + (VW'(1) << (2 * K));
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[i+1] <= n_s[i];
				tag_s[i+1] <= tag_s[i];
				if (rem_s[i] >= trial) begin
					rem_s[i+1] <= rem_s[i] - trial;
					root_s[i+1] <= root_s[i] | (RW'(1) << K);
				end else begin
					rem_s[i+1] <= rem_s[i];
					root_s[i+1] <= root_s[i];
				end
			end
		end
	end

	// triangle stage
	logic [RW-1:0] w;
	logic [NW-1:0] t_c;
	logic [2*RW-1:0] wsq;
	logic v_t, v_o;
	logic [NW-1:0] n_t, t_t;
	logic [RW-1:0] w_t;
	logic [TW-1:0] tag_t;
	assign w = (root_s[RW] - RW'(1)) >> 1;
	assign wsq = (2*RW)'(w) * (2*RW)'(w + RW'(1));
	assign t_c = NW'(wsq >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_t <= 1'b0;
			v_o <= 1'b0;
		end else if (en) begin
			v_t <= v_s[RW];
			v_o <= v_t;
		end
	end

	logic [NW-1:0] sec, fir;
	assign sec = n_t - t_t;
	assign fir = NW'(w_t) - sec;

	function automatic logic signed [OW-1:0] zz(input logic [NW-1:0] c);
		logic [NW-1:0] h;
		h = c >> 1;
		if (c[0]) return OW'(h + NW'(1));
		return OW'(-h);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			n_t <= n_s[RW];
			t_t <= t_c;
			w_t <= w;
			tag_t <= tag_s[RW];
			a <= zz(fir);
			b <= zz(sec);
			tag_out <= tag_t;
		end
	end
	assign vout = v_o;
endmodule

>>> rtl/cpia_divide.sv
// pipelined signed restoring divider, one quotient bit per stage
// depends on cpia_pkg; stalls with en
`timescale 1ns / 1ps
module cpia_divide #(
	parameter int PW = 60,
	parameter int OW = 17
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vin,
	input  logic signed [OW-1:0] a,
	input  logic signed [OW-1:0] b,
	input  logic [PW-1:0] pay_in,
	output logic vout,
	output logic [PW-1:0] pay_out,
	output cpia_pkg::outcome_t q
);
	import cpia_pkg::*;
	localparam int MW = OW;
	logic [MW:0] v_s;
	logic [MW-1:0] num_s [MW+1];
	logic [MW-1:0] rem_s [MW+1];
	logic [MW-1:0] den_s [MW+1];
	logic neg_s [MW+1];
	logic [PW-1:0] pay_s [MW+1];

	assign v_s[0] = vin;
	assign num_s[0] = a[MW-1] ? MW'(-a) : MW'(a);
	assign den_s[0] = b[MW-1] ? MW'(-b) : MW'(b);
	assign neg_s[0] = a[MW-1] ^ b[MW-1];
	assign rem_s[0] = '0;
	assign pay_s[0] = pay_in;

	for (genvar i = 0; i < MW; i++) begin : g_dv
		logic [MW:0] r2;
		assign r2 = {rem_s[i], num_s[i][MW-1]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i+1] <= den_s[i];
				neg_s[i+1] <= neg_s[i];
				pay_s[i+1] <= pay_s[i];
				if (r2 >= {1'b0, den_s[i]}) begin
					rem_s[i+1] <= MW'(r2 - {1'b0, den_s[i]});
					num_s[i+1] <= {num_s[i][MW-2:0], 1'b1};
				end else begin
					rem_s[i+1] <= MW'(r2);
					num_s[i+1] <= {num_s[i][MW-2:0], 1'b0};
				end
			end
		end
	end

	logic [OUTCOME_W-1:0] mag;
	assign mag = OUTCOME_W'(num_s[MW]);
	assign vout = v_s[MW];
	assign pay_out = pay_s[MW];
	assign q = (den_s[MW] == '0) ? '0 : (neg_s[MW] ? outcome_t'(-mag) : outcome_t'(mag));
endmodule
